@@ rtl/tct_pkg.sv @@
// Package for the tiled corner turn: shared types and constants.
// No dependencies; used by tiled_corner_turn.
package tct_pkg;

    localparam int WORD_BITS = 64;
    localparam int ROW_BITS  = 10;
    localparam int COL_BITS  = 8;
    localparam int SIDE_BITS = 7;

    localparam logic [0:0] REG_MAGNITUDE_MODE = 1'b0;
    localparam logic [0:0] REG_TILES_PER_SIDE = 1'b1;

    // Result word handed from the emitter to the output register.
    typedef struct packed {
        logic [WORD_BITS-1:0] out_real;
        logic [WORD_BITS-1:0] out_imag;
        logic [WORD_BITS-1:0] out_magnitude;
        logic [ROW_BITS-1:0]  dest_row;
        logic [COL_BITS-1:0]  dest_word;
        logic                 last;
    } result_t;

endpackage

@@ rtl/tct_sqrt_lane.sv @@
// One lane of the magnitude path: floor square root of re^2 + im^2.
// Pipelined restoring root, one result bit per stage. Depends on nothing else in rtl.
module tct_sqrt_lane #(
    parameter int COMPONENT_BITS = 16,
    parameter int DEPTH          = COMPONENT_BITS + 1
) (
    input  logic                      clk,
    input  logic                      advance,
    input  logic [COMPONENT_BITS-1:0] re,
    input  logic [COMPONENT_BITS-1:0] im,
    output logic [COMPONENT_BITS-1:0] root
);

    localparam int SQ_BITS = 2 * COMPONENT_BITS;
    localparam int RB      = COMPONENT_BITS;

    logic [SQ_BITS-1:0] rem_reg  [DEPTH];
    logic [SQ_BITS-1:0] rem_next [DEPTH];
    logic [RB-1:0]      res_reg  [DEPTH];
    logic [RB-1:0]      res_next [DEPTH];

    logic [RB-1:0] ar;
    logic [RB-1:0] ai;

    // Absolute values; the most negative code becomes its unsigned magnitude.
    assign ar = re[RB-1] ? (~re + 1'b1) : re;
    assign ai = im[RB-1] ? (~im + 1'b1) : im;

    // Stage 0 squares and sums; the sum of two squares fits in 2*RB bits.
    // Each later stage decides one root bit, from the top down.
    always_comb
    begin
        logic [SQ_BITS+1:0] trial;
        logic [SQ_BITS+1:0] rem_w;
        rem_next[0] = SQ_BITS'(ar) * SQ_BITS'(ar) + SQ_BITS'(ai) * SQ_BITS'(ai);
        res_next[0] = '0;
        for (int s = 1; s < DEPTH; s++)
        begin
            rem_w = {2'b00, rem_reg[s-1]};
            trial = ({2'b00, SQ_BITS'(res_reg[s-1])} << (RB-s+1))
                  + ((SQ_BITS+2)'(1) << (2*(RB-s)));
            if (rem_w >= trial)
            begin
                rem_next[s] = SQ_BITS'(rem_w - trial);
                res_next[s] = res_reg[s-1] | (RB'(1) << (RB-s));
            end
            else
            begin
                rem_next[s] = rem_reg[s-1];
                res_next[s] = res_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < DEPTH; s++)
            begin
                rem_reg[s] <= rem_next[s];
                res_reg[s] <= res_next[s];
            end
        end
    end

    assign root = res_reg[DEPTH-1];

endmodule

@@ rtl/tiled_corner_turn.sv @@
// Top level of the tiled corner turn: ping-pong tile memories, emitter,
// per-lane magnitude pipelines and the output register. Depends on tct_pkg
// and tct_sqrt_lane.
//
//  channel | dir | handshake         | payload
//  s_axis  | in  | tvalid/tready     | tdata: real_word[63:0], imag_word[127:64]
//  m_axis  | out | tvalid/tready     | tdata: out_real, out_imag, out_magnitude,
//          |     |                   |        dest_row, dest_word; tlast: last
//  cfg     | in  | cfg_we            | cfg_index, cfg_data
//
// Input words are taken one per cycle into one of two tile banks while the
// other bank is read out with one memory read per cycle; a transposed word
// gathers LANE_COUNT reads and a tile TILE_EDGE*TILE_EDGE reads, and the
// input stalls while both banks hold tiles. Results pass the memory read
// register, the word register, the magnitude delay line and the output
// register. Output stalls freeze the whole read pipeline.
// Reset clears counters and bank flags; tile memories need no clearing.
module tiled_corner_turn #(
    parameter int TILE_EDGE          = 16,
    parameter int LANE_COUNT         = 4,
    parameter int COMPONENT_BITS     = 16,
    parameter int MAX_TILES_PER_SIDE = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // real_word, imag_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [215:0] m_axis_tdata,   // out_real, out_imag, out_magnitude,
                                         // dest_row, dest_word, 6 pad bits
    output logic         m_axis_tlast,   // last
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int WB   = tct_pkg::WORD_BITS;
    localparam int WPR  = TILE_EDGE / LANE_COUNT;
    localparam int WPT  = TILE_EDGE * WPR;
    localparam int AB   = (WPT > 1) ? $clog2(WPT) : 1;
    localparam int CB   = (TILE_EDGE > 1) ? $clog2(TILE_EDGE) : 1;
    localparam int OWB  = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int LB   = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int TB   = 6;
    localparam int DEPTH = COMPONENT_BITS + 1;
    localparam int VLANES = (LANE_COUNT * COMPONENT_BITS > WB) ?
                            WB / COMPONENT_BITS : LANE_COUNT;

    // Configuration.
    logic                           mag_mode_reg;
    logic [tct_pkg::SIDE_BITS-1:0]  side_cfg_reg;
    logic [tct_pkg::SIDE_BITS-1:0]  side_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_mode_reg <= 1'b0;
            side_cfg_reg <= 7'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tct_pkg::REG_MAGNITUDE_MODE: mag_mode_reg <= cfg_data[0];
                tct_pkg::REG_TILES_PER_SIDE: side_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (side_cfg_reg == '0)
            side_eff = 7'd1;
        else if (side_cfg_reg > 7'(MAX_TILES_PER_SIDE))
            side_eff = 7'(MAX_TILES_PER_SIDE);
        else
            side_eff = side_cfg_reg;
    end

    // Two tile banks per component.
    logic [WB-1:0] re_mem [2*WPT];
    logic [WB-1:0] im_mem [2*WPT];

    logic          wr_bank_reg;
    logic [AB-1:0] wpos_reg;
    logic [1:0]    full_reg;     // bank holds a complete tile not yet fully read out
    logic [TB-1:0] trow_reg, tcol_reg;
    logic [TB-1:0] btrow_reg [2];  // tile position of the tile held in each bank
    logic [TB-1:0] btcol_reg [2];

    // Readout sequencer.
    logic          rd_busy_reg;
    logic          rd_bank_reg;
    logic [CB-1:0] rc_reg;
    logic [OWB-1:0] sw_reg;      // source word of dest column rc
    logic [LB-1:0] sl_reg;       // source lane of dest column rc
    logic [OWB-1:0] row_reg;
    logic [LB-1:0] rl_reg;
    logic [LB-1:0] rd_lane;

    logic advance;
    logic in_fire;
    logic tile_done;
    logic rd_last;

    assign s_axis_tready = !full_reg[wr_bank_reg];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign tile_done = in_fire && (wpos_reg == AB'(WPT-1));

    // Lane of the output word that the current memory read fills.
    assign rd_lane = rl_reg;
    assign rd_last = rd_busy_reg && (rc_reg == CB'(TILE_EDGE-1)) &&
                     (row_reg == OWB'(WPR-1)) && (rl_reg == LB'(LANE_COUNT-1));

    // Write side: fill counter and tile position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_bank_reg  <= 1'b0;
            wpos_reg     <= '0;
            trow_reg     <= '0;
            tcol_reg     <= '0;
            btrow_reg[0] <= '0;
            btrow_reg[1] <= '0;
            btcol_reg[0] <= '0;
            btcol_reg[1] <= '0;
        end
        else if (in_fire)
        begin
            if (tile_done)
            begin
                logic [TB-1:0] r, c;
                r = ({1'b0, trow_reg} >= side_eff) ? '0 : trow_reg;
                c = ({1'b0, tcol_reg} >= side_eff) ? '0 : tcol_reg;
                wpos_reg    <= '0;
                wr_bank_reg <= !wr_bank_reg;
                btrow_reg[wr_bank_reg] <= r;
                btcol_reg[wr_bank_reg] <= c;
                if ({1'b0, c} + 7'd1 >= side_eff)
                begin
                    tcol_reg <= '0;
                    trow_reg <= ({1'b0, r} + 7'd1 >= side_eff) ? '0 : r + 1'b1;
                end
                else
                begin
                    tcol_reg <= c + 1'b1;
                    trow_reg <= r;
                end
            end
            else
            begin
                wpos_reg <= wpos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            re_mem[{wr_bank_reg, wpos_reg}] <= s_axis_tdata[WB-1:0];
            im_mem[{wr_bank_reg, wpos_reg}] <= s_axis_tdata[2*WB-1:WB];
        end
    end

    // Readout walks dest column c, output word ow, then each lane (source
    // row) one memory read per cycle while the output is not stalled; lanes gather in a collect register.
    logic [AB-1:0] rd_addr;
    assign rd_addr = AB'((32'(row_reg) * LANE_COUNT + 32'(rl_reg)) * WPR
                         + 32'(sw_reg));

    logic rd_step;
    assign rd_step = rd_busy_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg    <= '0;
            rd_busy_reg <= 1'b0;
            rd_bank_reg <= 1'b0;
            rc_reg      <= '0;
            sw_reg      <= '0;
            sl_reg      <= '0;
            row_reg     <= '0;
            rl_reg      <= '0;
        end
        else
        begin
            logic [1:0] f;
            f = full_reg;
            if (tile_done)
                f[wr_bank_reg] = 1'b1;
            if (!rd_busy_reg && f[rd_bank_reg])
            begin
                rd_busy_reg <= 1'b1;
            end
            else if (rd_step)
            begin
                rl_reg <= rl_reg + 1'b1;
                if (rl_reg == LB'(LANE_COUNT-1))
                begin
                    rl_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                    if (row_reg == OWB'(WPR-1))
                    begin
                        row_reg <= '0;
                        rc_reg  <= rc_reg + 1'b1;
                        if (sl_reg == LB'(LANE_COUNT-1))
                        begin
                            sl_reg <= '0;
                            sw_reg <= sw_reg + 1'b1;
                        end
                        else
                        begin
                            sl_reg <= sl_reg + 1'b1;
                        end
                    end
                end
                if (rd_last)
                begin
                    rd_busy_reg <= 1'b0;
                    rc_reg      <= '0;
                    sw_reg      <= '0;
                    sl_reg      <= '0;
                    f[rd_bank_reg] = 1'b0;
                    rd_bank_reg <= !rd_bank_reg;
                end
            end
            full_reg <= f;
        end
    end

    // Registered memory read and lane extraction.
    logic [WB-1:0] re_rd_reg, im_rd_reg;
    logic          rv_reg;
    logic [LB-1:0] rlane_reg;
    logic [LB-1:0] srcl_reg;
    logic          rend_reg;
    logic [tct_pkg::ROW_BITS-1:0] rrow_reg;
    logic [tct_pkg::COL_BITS-1:0] rword_reg;
    logic          rlast_reg;

    always_ff @(posedge clk)
    begin
        if (rd_step)
        begin
            re_rd_reg <= re_mem[{rd_bank_reg, rd_addr}];
            im_rd_reg <= im_mem[{rd_bank_reg, rd_addr}];
        end
        if (advance)
        begin
            rlane_reg <= rd_lane;
            srcl_reg  <= sl_reg;
            rend_reg  <= (rl_reg == LB'(LANE_COUNT-1));
            rrow_reg  <= tct_pkg::ROW_BITS'(32'(btcol_reg[rd_bank_reg]) * TILE_EDGE
                                            + 32'(rc_reg));
            rword_reg <= tct_pkg::COL_BITS'(32'(btrow_reg[rd_bank_reg]) * WPR
                                            + 32'(row_reg));
            rlast_reg <= rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (advance)
            rv_reg <= rd_step;
    end

    // Selected component of the fetched word.
    logic [COMPONENT_BITS-1:0] re_c, im_c;
    assign re_c = COMPONENT_BITS'(re_rd_reg >> (32'(srcl_reg) * COMPONENT_BITS));
    assign im_c = COMPONENT_BITS'(im_rd_reg >> (32'(srcl_reg) * COMPONENT_BITS));

    // Collect lanes into a word.
    logic [LANE_COUNT*COMPONENT_BITS-1:0] cre_reg, cim_reg;
    logic [LANE_COUNT*COMPONENT_BITS-1:0] cre_w, cim_w;
    logic wv_reg;
    logic [tct_pkg::ROW_BITS-1:0] wrow_reg;
    logic [tct_pkg::COL_BITS-1:0] wword_reg;
    logic wlast_reg;

    always_comb
    begin
        cre_w = cre_reg;
        cim_w = cim_reg;
        for (int l = 0; l < LANE_COUNT; l++)
        begin
            if (rlane_reg == LB'(l))
            begin
                cre_w[l*COMPONENT_BITS +: COMPONENT_BITS] = re_c;
                cim_w[l*COMPONENT_BITS +: COMPONENT_BITS] = im_c;
            end
        end
    end

    logic [LANE_COUNT*COMPONENT_BITS-1:0] wre_reg, wim_reg;

    always_ff @(posedge clk)
    begin
        if (advance && rv_reg)
        begin
            cre_reg <= cre_w;
            cim_reg <= cim_w;
        end
        if (advance)
        begin
            wre_reg   <= cre_w;
            wim_reg   <= cim_w;
            wrow_reg  <= rrow_reg;
            wword_reg <= rword_reg;
            wlast_reg <= rlast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg <= 1'b0;
        else if (advance)
            wv_reg <= rv_reg && rend_reg;
    end

    // Magnitude lanes and a delay line for the word alongside them.
    logic [LANE_COUNT*COMPONENT_BITS-1:0] mag_w;
    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_lane
        tct_sqrt_lane #(.COMPONENT_BITS(COMPONENT_BITS), .DEPTH(DEPTH)) u_sqrt (
            .clk     (clk),
            .advance (advance),
            .re      (wre_reg[l*COMPONENT_BITS +: COMPONENT_BITS]),
            .im      (wim_reg[l*COMPONENT_BITS +: COMPONENT_BITS]),
            .root    (mag_w[l*COMPONENT_BITS +: COMPONENT_BITS])
        );
    end

    tct_pkg::result_t pipe_reg [DEPTH];
    logic [DEPTH-1:0] pv_reg;
    tct_pkg::result_t head;

    // Merge real and imaginary lanes into the result word outside magnitude mode; only valid lanes land below bit 64.
    always_comb
    begin
        head = '0;
        for (int l = 0; l < VLANES; l++)
        begin
            if (!mag_mode_reg)
            begin
                head.out_real[l*COMPONENT_BITS +: COMPONENT_BITS] =
                    wre_reg[l*COMPONENT_BITS +: COMPONENT_BITS];
                head.out_imag[l*COMPONENT_BITS +: COMPONENT_BITS] =
                    wim_reg[l*COMPONENT_BITS +: COMPONENT_BITS];
            end
        end
        head.dest_row  = wrow_reg;
        head.dest_word = wword_reg;
        head.last      = wlast_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pipe_reg[0] <= head;
            for (int s = 1; s < DEPTH; s++)
                pipe_reg[s] <= pipe_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (advance)
            pv_reg <= {pv_reg[DEPTH-2:0], wv_reg};
    end

    tct_pkg::result_t tail;
    always_comb
    begin
        tail = pipe_reg[DEPTH-1];
        if (mag_mode_reg)
        begin
            for (int l = 0; l < VLANES; l++)
                tail.out_magnitude[l*COMPONENT_BITS +: COMPONENT_BITS] =
                    mag_w[l*COMPONENT_BITS +: COMPONENT_BITS];
        end
    end

    // Output register; the pipeline moves whenever it is empty or taken.
    tct_pkg::result_t out_reg;
    logic out_v_reg;

    assign advance = !out_v_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= pv_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= tail;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {6'b0, out_reg.dest_word, out_reg.dest_row,
                            out_reg.out_magnitude, out_reg.out_imag, out_reg.out_real};

endmodule
